// ===== design/dgc_pkg.sv =====
// Shared types, constants and the control store for the disk geometry block.
// Holds the microcode program, the sectors-per-track table and the divider
// request/response structs. Depends on nothing.
`timescale 1ns / 1ps

package dgc_pkg;

    // Field and datapath widths.
    localparam int TOTAL_W = 32;
    localparam int KIND_W  = 2;
    localparam int CYL_W   = 16;
    localparam int HEAD_W  = 5;
    localparam int SPT_W   = 8;
    localparam int DVSR_W  = 12;
    localparam int CNT_W   = 5;

    // Source kinds.
    localparam logic [KIND_W-1:0] KIND_FILE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYNTH = 2'd1;

    // Geometry rule constants.
    localparam logic [SPT_W-1:0]   SYNTH_SPT   = 8'd32;
    localparam logic [TOTAL_W-1:0] SMALL_DISK  = 32'd1048576;
    localparam logic [TOTAL_W-1:0] SMALL_CYL   = 32'd1023;
    localparam logic [TOTAL_W-1:0] CYL_A       = 32'd16383;
    localparam logic [TOTAL_W-1:0] CYL_B       = 32'd32767;
    localparam logic [TOTAL_W-1:0] CYL_MAX     = 32'd65535;
    localparam logic [TOTAL_W-1:0] CYL_MAX_SYN = 32'd65534;
    localparam logic [HEAD_W-1:0]  HEAD_FIRST  = 5'd1;
    localparam logic [HEAD_W-1:0]  HEAD_SRCH   = 5'd4;
    localparam logic [HEAD_W-1:0]  HEAD_MIN_B  = 5'd5;
    localparam logic [HEAD_W-1:0]  HEAD_LAST   = 5'd16;
    localparam logic [1:0]         SPT_IDX_LAST = 2'd2;

    typedef logic [4:0] pc_t;

    // Datapath operations carried in a control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIV_START,
        OP_DIV_WAIT,
        OP_INC_HEAD,
        OP_SRCH_INIT,
        OP_NEXT_SPT,
        OP_EMIT,
        OP_EMIT_ZERO
    } op_t;

    // Jump conditions carried in a control word.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_EMPTY,
        C_NOT_SYNTH,
        C_SYNTH_STOP,
        C_NOT_EXACT,
        C_ACCEPT,
        C_HEAD_MAX,
        C_LAST_SPT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    // Program addresses.
    localparam pc_t A_IDLE      = 5'd0;
    localparam pc_t A_CHK_EMPTY = 5'd1;
    localparam pc_t A_CHK_SYNTH = 5'd2;
    localparam pc_t A_S_DIV     = 5'd3;
    localparam pc_t A_S_WAIT    = 5'd4;
    localparam pc_t A_S_TEST    = 5'd5;
    localparam pc_t A_S_NEXT    = 5'd6;
    localparam pc_t A_S_EXACT   = 5'd7;
    localparam pc_t A_S_EMIT    = 5'd8;
    localparam pc_t A_C_INIT    = 5'd9;
    localparam pc_t A_C_DIV     = 5'd10;
    localparam pc_t A_C_WAIT    = 5'd11;
    localparam pc_t A_C_TEST    = 5'd12;
    localparam pc_t A_C_HEADMAX = 5'd13;
    localparam pc_t A_C_NEXT    = 5'd14;
    localparam pc_t A_C_SPTMAX  = 5'd15;
    localparam pc_t A_C_NEXTSPT = 5'd16;
    localparam pc_t A_C_EMIT    = 5'd17;
    localparam pc_t A_EMPTY     = 5'd18;

    // Divider request and response.
    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] dividend;
        logic [DVSR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] quotient;
        logic               rem_zero;
    } div_rsp_t;

    function automatic ucode_t mk_word(op_t op, cond_t cond, pc_t target);
        ucode_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // The control store. Each step names one datapath operation and an
    // optional jump; a step that does not jump falls through to the next.
    function automatic ucode_t ucode_rom(pc_t pc);
        ucode_t w;
        unique case (pc)
            A_IDLE:      w = mk_word(OP_ACCEPT,    C_NEVER,      A_IDLE);
            A_CHK_EMPTY: w = mk_word(OP_NOP,       C_EMPTY,      A_EMPTY);
            A_CHK_SYNTH: w = mk_word(OP_NOP,       C_NOT_SYNTH,  A_C_INIT);
            A_S_DIV:     w = mk_word(OP_DIV_START, C_NEVER,      A_IDLE);
            A_S_WAIT:    w = mk_word(OP_DIV_WAIT,  C_NEVER,      A_IDLE);
            A_S_TEST:    w = mk_word(OP_NOP,       C_SYNTH_STOP, A_S_EXACT);
            A_S_NEXT:    w = mk_word(OP_INC_HEAD,  C_ALWAYS,     A_S_DIV);
            A_S_EXACT:   w = mk_word(OP_NOP,       C_NOT_EXACT,  A_C_INIT);
            A_S_EMIT:    w = mk_word(OP_EMIT,      C_ALWAYS,     A_IDLE);
            A_C_INIT:    w = mk_word(OP_SRCH_INIT, C_NEVER,      A_IDLE);
            A_C_DIV:     w = mk_word(OP_DIV_START, C_NEVER,      A_IDLE);
            A_C_WAIT:    w = mk_word(OP_DIV_WAIT,  C_NEVER,      A_IDLE);
            A_C_TEST:    w = mk_word(OP_NOP,       C_ACCEPT,     A_C_EMIT);
            A_C_HEADMAX: w = mk_word(OP_NOP,       C_HEAD_MAX,   A_C_SPTMAX);
            A_C_NEXT:    w = mk_word(OP_INC_HEAD,  C_ALWAYS,     A_C_DIV);
            A_C_SPTMAX:  w = mk_word(OP_INC_HEAD,  C_LAST_SPT,   A_C_EMIT);
            A_C_NEXTSPT: w = mk_word(OP_NEXT_SPT,  C_ALWAYS,     A_C_DIV);
            A_C_EMIT:    w = mk_word(OP_EMIT,      C_ALWAYS,     A_IDLE);
            A_EMPTY:     w = mk_word(OP_EMIT_ZERO, C_ALWAYS,     A_IDLE);
            default:     w = mk_word(OP_NOP,       C_ALWAYS,     A_IDLE);
        endcase
        return w;
    endfunction

    // Sectors per track for the general search.
    function automatic logic [SPT_W-1:0] spt_of(logic [1:0] idx);
        logic [SPT_W-1:0] s;
        unique case (idx)
            2'd0:    s = 8'd63;
            2'd1:    s = 8'd127;
            default: s = 8'd255;
        endcase
        return s;
    endfunction

endpackage

// ===== design/dgc_div.sv =====
// Serial restoring divider: 32-bit dividend by a 12-bit divisor, one
// quotient bit per cycle. Depends on dgc_pkg for widths and the
// request/response structs.
`timescale 1ns / 1ps

module dgc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dgc_pkg::div_req_t req,
    output dgc_pkg::div_rsp_t rsp
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [dgc_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [dgc_pkg::TOTAL_W-1:0]      quo_reg, quo_next;
    logic [dgc_pkg::DVSR_W-1:0]       rem_reg, rem_next;
    logic [dgc_pkg::DVSR_W-1:0]       dvsr_reg, dvsr_next;
    logic [dgc_pkg::DVSR_W:0]         shifted;
    logic [dgc_pkg::DVSR_W+1:0]       diff;

    // The shifted partial remainder is below twice the divisor, so one
    // trial subtraction settles each bit.
    assign shifted = {rem_reg, quo_reg[dgc_pkg::TOTAL_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '1;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (diff[dgc_pkg::DVSR_W+1])
            begin
                rem_next = shifted[dgc_pkg::DVSR_W-1:0];
                quo_next = {quo_reg[dgc_pkg::TOTAL_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[dgc_pkg::DVSR_W-1:0];
                quo_next = {quo_reg[dgc_pkg::TOTAL_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - dgc_pkg::CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.rem_zero = (rem_reg == '0);

endmodule

// ===== design/disk_geometry_from_capacity_unit.sv =====
// Top level of the disk geometry block: a microcoded sequencer that drives a
// small datapath and a shared serial divider. Depends on dgc_pkg and dgc_div.
`timescale 1ns / 1ps

// The block turns a disk capacity in 512-byte blocks and a source kind into a
// cylinder/head/sector geometry, one result transaction per input transaction.
// It works on one transaction at a time: in_stall is low only while the
// sequencer sits at its idle step. Every candidate geometry costs one 32-bit
// division in the shared serial divider, which produces one quotient bit per
// cycle. A plain file or card needs 1 to 39 candidates, a file with a
// synthesized partition block up to 55; an empty file needs no division.
// The result sits in an output register, so a new transaction is taken
// while the previous result still waits under out_stall.

module disk_geometry_from_capacity_unit (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dgc_pkg::TOTAL_W-1:0]   total_blocks,
    input  logic [dgc_pkg::KIND_W-1:0]    source_kind,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          updated,
    output logic [dgc_pkg::CYL_W-1:0]     cylinders,
    output logic [dgc_pkg::HEAD_W-1:0]    heads,
    output logic [dgc_pkg::SPT_W-1:0]     sectors_per_track
);

    // Sequencer state.
    dgc_pkg::pc_t    pc_reg, pc_next;
    dgc_pkg::ucode_t uw;
    logic            hold;
    logic            cond_true;

    // Datapath registers.
    logic [dgc_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                        synth_reg, synth_next;
    logic                        empty_reg, empty_next;
    logic                        small_reg, small_next;
    logic [dgc_pkg::HEAD_W-1:0]  head_reg, head_next;
    logic [dgc_pkg::SPT_W-1:0]   spt_reg, spt_next;
    logic [1:0]                  spt_idx_reg, spt_idx_next;
    logic [dgc_pkg::TOTAL_W-1:0] cyl_reg, cyl_next;
    logic                        exact_reg, exact_next;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic                        updated_reg, updated_next;
    logic [dgc_pkg::CYL_W-1:0]   cyl_out_reg, cyl_out_next;
    logic [dgc_pkg::HEAD_W-1:0]  head_out_reg, head_out_next;
    logic [dgc_pkg::SPT_W-1:0]   spt_out_reg, spt_out_next;
    logic                        out_free;

    // Divider interface.
    dgc_pkg::div_req_t           div_req;
    dgc_pkg::div_rsp_t           div_rsp;
    logic [dgc_pkg::HEAD_W+dgc_pkg::SPT_W-1:0] divisor_full;

    logic                        geo_accept;
    logic [dgc_pkg::TOTAL_W-1:0] cyl_limit;

    dgc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The current control word comes straight from the control store.
    assign uw = dgc_pkg::ucode_rom(pc_reg);

    // Candidate divisor is heads times sectors per track; at most 16 * 255,
    // which fits the divider's 12-bit divisor.
    assign divisor_full     = head_reg * spt_reg;
    assign div_req.start    = (uw.op == dgc_pkg::OP_DIV_START);
    assign div_req.dividend = total_reg;
    assign div_req.divisor  = divisor_full[dgc_pkg::DVSR_W-1:0];

    // Cylinder limit rules for the general search. A small disk must stay
    // within 1023 cylinders; a larger one is taken under 16383 cylinders, under
    // 32767 with five or more heads, or up to the hard limit.
    assign cyl_limit  = synth_reg ? dgc_pkg::CYL_MAX_SYN : dgc_pkg::CYL_MAX;
    assign geo_accept = small_reg ? (cyl_reg <= dgc_pkg::SMALL_CYL)
                                  : ((cyl_reg < dgc_pkg::CYL_A) ||
                                     ((cyl_reg < dgc_pkg::CYL_B) &&
                                      (head_reg >= dgc_pkg::HEAD_MIN_B)) ||
                                     (cyl_reg <= cyl_limit));

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall = (uw.op != dgc_pkg::OP_ACCEPT);

    // Jump condition decoder.
    always_comb
    begin
        unique case (uw.cond)
            dgc_pkg::C_NEVER:      cond_true = 1'b0;
            dgc_pkg::C_ALWAYS:     cond_true = 1'b1;
            dgc_pkg::C_EMPTY:      cond_true = empty_reg;
            dgc_pkg::C_NOT_SYNTH:  cond_true = !synth_reg;
            // The 32-sector search stops at an exact fit under the limit, or
            // at the last head count whatever the fit.
            dgc_pkg::C_SYNTH_STOP: cond_true = ((cyl_reg <= dgc_pkg::CYL_MAX_SYN) &&
                                                exact_reg) ||
                                               (head_reg == dgc_pkg::HEAD_LAST);
            dgc_pkg::C_NOT_EXACT:  cond_true = !exact_reg;
            dgc_pkg::C_ACCEPT:     cond_true = geo_accept;
            dgc_pkg::C_HEAD_MAX:   cond_true = (head_reg == dgc_pkg::HEAD_LAST);
            dgc_pkg::C_LAST_SPT:   cond_true = (spt_idx_reg == dgc_pkg::SPT_IDX_LAST);
            default:               cond_true = 1'b0;
        endcase
    end

    // A step holds while waiting for an input transaction, for the divider,
    // or for room in the output register.
    always_comb
    begin
        unique case (uw.op) inside
            dgc_pkg::OP_ACCEPT:    hold = !in_valid;
            dgc_pkg::OP_DIV_WAIT:  hold = !div_rsp.done;
            dgc_pkg::OP_EMIT,
            dgc_pkg::OP_EMIT_ZERO: hold = !out_free;
            default:               hold = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (cond_true)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + dgc_pkg::pc_t'(1);
        end
    end

    // Datapath operations.
    always_comb
    begin
        total_next   = total_reg;
        synth_next   = synth_reg;
        empty_next   = empty_reg;
        small_next   = small_reg;
        head_next    = head_reg;
        spt_next     = spt_reg;
        spt_idx_next = spt_idx_reg;
        cyl_next     = cyl_reg;
        exact_next   = exact_reg;
        unique case (uw.op)
            dgc_pkg::OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    total_next   = total_blocks;
                    synth_next   = (source_kind == dgc_pkg::KIND_SYNTH);
                    // Only files can be empty; a zero-size card is computed.
                    empty_next   = ((source_kind == dgc_pkg::KIND_FILE) ||
                                    (source_kind == dgc_pkg::KIND_SYNTH)) &&
                                   (total_blocks == '0);
                    small_next   = (total_blocks <= dgc_pkg::SMALL_DISK);
                    head_next    = dgc_pkg::HEAD_FIRST;
                    spt_next     = dgc_pkg::SYNTH_SPT;
                    spt_idx_next = 2'd0;
                end
            end
            dgc_pkg::OP_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    cyl_next   = div_rsp.quotient;
                    exact_next = div_rsp.rem_zero;
                end
            end
            dgc_pkg::OP_INC_HEAD:
            begin
                head_next = head_reg + dgc_pkg::HEAD_W'(1);
            end
            dgc_pkg::OP_SRCH_INIT:
            begin
                head_next    = dgc_pkg::HEAD_SRCH;
                spt_idx_next = 2'd0;
                spt_next     = dgc_pkg::spt_of(2'd0);
            end
            dgc_pkg::OP_NEXT_SPT:
            begin
                head_next    = dgc_pkg::HEAD_SRCH;
                spt_idx_next = spt_idx_reg + 2'd1;
                spt_next     = dgc_pkg::spt_of(spt_idx_reg + 2'd1);
            end
            default:
            begin
            end
        endcase
    end

    // Output register. A file with a synthesized partition block reports one
    // extra cylinder; the count wraps to 16 bits. When nothing fitted, the
    // head register has run on to 17 and the last quotient is reported.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        updated_next   = updated_reg;
        cyl_out_next   = cyl_out_reg;
        head_out_next  = head_out_reg;
        spt_out_next   = spt_out_reg;
        if (uw.op == dgc_pkg::OP_EMIT && out_free)
        begin
            out_valid_next = 1'b1;
            updated_next   = 1'b1;
            cyl_out_next   = cyl_reg[dgc_pkg::CYL_W-1:0] +
                             {{(dgc_pkg::CYL_W-1){1'b0}}, synth_reg};
            head_out_next  = head_reg;
            spt_out_next   = spt_reg;
        end
        else if (uw.op == dgc_pkg::OP_EMIT_ZERO && out_free)
        begin
            out_valid_next = 1'b1;
            updated_next   = 1'b0;
            cyl_out_next   = '0;
            head_out_next  = '0;
            spt_out_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= dgc_pkg::A_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg    <= total_next;
        synth_reg    <= synth_next;
        empty_reg    <= empty_next;
        small_reg    <= small_next;
        head_reg     <= head_next;
        spt_reg      <= spt_next;
        spt_idx_reg  <= spt_idx_next;
        cyl_reg      <= cyl_next;
        exact_reg    <= exact_next;
        updated_reg  <= updated_next;
        cyl_out_reg  <= cyl_out_next;
        head_out_reg <= head_out_next;
        spt_out_reg  <= spt_out_next;
    end

    assign out_valid         = out_valid_reg;
    assign updated           = updated_reg;
    assign cylinders         = cyl_out_reg;
    assign heads             = head_out_reg;
    assign sectors_per_track = spt_out_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for disk_geometry_from_capacity_unit.
// Depends on dgc_pkg for field widths, source kinds and the geometry rule constants.
`timescale 1ns / 1ps

module tb_top;

    // The card kind and the unused fourth kind are not named in the package.
    localparam logic [dgc_pkg::KIND_W-1:0] KIND_CARD  = 2'd2;
    localparam logic [dgc_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    // The long receiver hold-off below lasts HOLD_CYCLES, and during it the block
    // may accept one more request and then sit stalled. The watchdog limit leaves
    // a wide margin over both the hold-off and the longest correct transaction.
    localparam int HOLD_CYCLES  = 5000;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 2500;
    localparam int PHASE_ITEMS  = 75;

    typedef struct packed {
        logic                       upd;
        logic [dgc_pkg::CYL_W-1:0]  cyl;
        logic [dgc_pkg::HEAD_W-1:0] hd;
        logic [dgc_pkg::SPT_W-1:0]  spt;
    } geom_t;

    typedef struct packed {
        logic [dgc_pkg::TOTAL_W-1:0] blocks;
        logic [dgc_pkg::KIND_W-1:0]  kind;
        logic                        known;
        geom_t                       want;
    } probe_row_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         in_stall;
    logic [dgc_pkg::TOTAL_W-1:0]  total_blocks = '0;
    logic [dgc_pkg::KIND_W-1:0]   source_kind  = '0;
    logic                         out_valid;
    logic                         out_stall    = 1'b0;
    logic                         updated;
    logic [dgc_pkg::CYL_W-1:0]    cylinders;
    logic [dgc_pkg::HEAD_W-1:0]   heads;
    logic [dgc_pkg::SPT_W-1:0]    sectors_per_track;

    geom_t      pending_geoms[$];
    probe_row_t probe_rows[$];

    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    int n_sent    = 0;
    int n_checked = 0;
    int n_errors  = 0;

    disk_geometry_from_capacity_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .total_blocks      (total_blocks),
        .source_kind       (source_kind),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .updated           (updated),
        .cylinders         (cylinders),
        .heads             (heads),
        .sectors_per_track (sectors_per_track)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Geometry predictor. All arithmetic is carried in 64 bits so that the
    // exact-fit product and the divisions never overflow; only the final
    // cylinder count is cut to 16 bits, which gives the C-style wrap.
    function automatic geom_t calc_geometry(logic [dgc_pkg::TOTAL_W-1:0] blocks,
                                            logic [dgc_pkg::KIND_W-1:0] kind);
        geom_t       g;
        logic [63:0] blk;
        logic [63:0] lim;
        logic [63:0] hd;
        logic [63:0] cyl;
        logic [63:0] spt;
        bit          synth;
        bit          found;
        bit          ok;
        int          idx;
        g     = '0;
        blk   = 64'(blocks);
        synth = (kind == dgc_pkg::KIND_SYNTH);
        lim   = synth ? 64'(dgc_pkg::CYL_MAX_SYN) : 64'(dgc_pkg::CYL_MAX);
        // An empty file leaves the geometry untouched; a card of size zero
        // falls through and is computed like any other capacity.
        if ((kind == dgc_pkg::KIND_FILE || kind == dgc_pkg::KIND_SYNTH) && blocks == '0)
            return g;
        if (synth)
        begin
            // Walk the head count up from one until the 32-sector quotient
            // divides exactly and stays under the limit, or sixteen is reached.
            hd  = 64'(dgc_pkg::HEAD_FIRST);
            cyl = blk / 64'(dgc_pkg::SYNTH_SPT);
            while (hd < 64'(dgc_pkg::HEAD_LAST) &&
                   (cyl > lim || hd * cyl * 64'(dgc_pkg::SYNTH_SPT) != blk))
            begin
                hd  = hd + 1;
                cyl = blk / (64'(dgc_pkg::SYNTH_SPT) * hd);
            end
            // A fit at sixteen heads counts even if it exceeds the limit.
            if (hd * cyl * 64'(dgc_pkg::SYNTH_SPT) == blk)
            begin
                g.upd = 1'b1;
                g.cyl = dgc_pkg::CYL_W'(cyl + 1);
                g.hd  = dgc_pkg::HEAD_W'(hd);
                g.spt = dgc_pkg::SYNTH_SPT;
                return g;
            end
        end
        found = 1'b0;
        idx   = 0;
        spt   = 64'd63;
        hd    = 64'(dgc_pkg::HEAD_SRCH);
        cyl   = '0;
        while (idx < 3 && !found)
        begin
            case (idx)
                0:       spt = 64'd63;
                1:       spt = 64'd127;
                default: spt = 64'd255;
            endcase
            hd = 64'(dgc_pkg::HEAD_SRCH);
            while (hd <= 64'(dgc_pkg::HEAD_LAST) && !found)
            begin
                cyl = blk / (hd * spt);
                if (blk <= 64'(dgc_pkg::SMALL_DISK))
                    ok = (cyl <= 64'(dgc_pkg::SMALL_CYL));
                else
                    ok = (cyl < 64'(dgc_pkg::CYL_A)) ||
                         (cyl < 64'(dgc_pkg::CYL_B) && hd >= 64'(dgc_pkg::HEAD_MIN_B)) ||
                         (cyl <= lim);
                if (ok)
                    found = 1'b1;
                else
                    hd = hd + 1;
            end
            if (!found)
                idx = idx + 1;
        end
        // When nothing fits, the last candidate tried (16 heads, 255 sectors)
        // supplies the cylinder count and the head count ends at seventeen.
        if (synth)
            cyl = cyl + 1;
        g.upd = 1'b1;
        g.cyl = dgc_pkg::CYL_W'(cyl);
        g.hd  = dgc_pkg::HEAD_W'(hd);
        g.spt = dgc_pkg::SPT_W'(spt);
        return g;
    endfunction

    // Random capacity, shaped so that most requests hit interesting regions:
    // small disks, the small-disk boundary, exact synthesized-block fits, and
    // capacities sitting on the cylinder thresholds of the general search.
    function automatic logic [dgc_pkg::TOTAL_W-1:0] pick_capacity(
        logic [dgc_pkg::KIND_W-1:0] kind);
        logic [63:0] hd;
        logic [63:0] spt;
        logic [63:0] cyl;
        logic [63:0] val;
        int          sel;
        sel = $urandom_range(9);
        if (kind == dgc_pkg::KIND_SYNTH && $urandom_range(1) == 0)
            sel = 5;
        case (sel)
            0, 1:
                val = $urandom_range(1048576);
            2:
                val = 64'd1048570 + $urandom_range(12);
            3, 4:
                val = $urandom_range(267386880);
            5:
            begin
                hd  = $urandom_range(16, 1);
                cyl = $urandom_range(70000, 1);
                val = 64'(dgc_pkg::SYNTH_SPT) * hd * cyl;
            end
            6, 8:
            begin
                hd = $urandom_range(16, 4);
                case ($urandom_range(2))
                    0:       spt = 64'd63;
                    1:       spt = 64'd127;
                    default: spt = 64'd255;
                endcase
                case ($urandom_range(8))
                    0:       cyl = 64'd1023;
                    1:       cyl = 64'd1024;
                    2:       cyl = 64'd16382;
                    3:       cyl = 64'd16383;
                    4:       cyl = 64'd32766;
                    5:       cyl = 64'd32767;
                    6:       cyl = 64'd65534;
                    7:       cyl = 64'd65535;
                    default: cyl = 64'd65536;
                endcase
                val = hd * spt * cyl;
                if (sel == 6)
                    val = val + $urandom_range(hd * spt) - (hd * spt) / 2;
            end
            7:
                val = $urandom();
            default:
                val = $urandom() >> $urandom_range(31);
        endcase
        return dgc_pkg::TOTAL_W'(val);
    endfunction

    function automatic logic [dgc_pkg::KIND_W-1:0] pick_kind();
        logic [dgc_pkg::KIND_W-1:0] k;
        case ($urandom_range(9))
            0, 1, 2:    k = dgc_pkg::KIND_FILE;
            3, 4, 5, 6: k = dgc_pkg::KIND_SYNTH;
            7, 8:       k = KIND_CARD;
            default:    k = KIND_SPARE;
        endcase
        return k;
    endfunction

    task automatic add_probe(input logic [dgc_pkg::TOTAL_W-1:0] blocks,
                             input logic [dgc_pkg::KIND_W-1:0] kind,
                             input logic known, input logic upd, input int cyl,
                             input int hd, input int spt);
        probe_row_t r;
        r.blocks   = blocks;
        r.kind     = kind;
        r.known    = known;
        r.want.upd = upd;
        r.want.cyl = dgc_pkg::CYL_W'(cyl);
        r.want.hd  = dgc_pkg::HEAD_W'(hd);
        r.want.spt = dgc_pkg::SPT_W'(spt);
        probe_rows.push_back(r);
    endtask

    // Offers one request and returns at the edge where it is accepted. The
    // valid line is left high, so a following call can continue without a gap.
    task automatic send_request(input logic [dgc_pkg::TOTAL_W-1:0] blocks,
                                input logic [dgc_pkg::KIND_W-1:0] kind,
                                input geom_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        total_blocks <= blocks;
        source_kind  <= kind;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_geoms.push_back(want);
        n_sent++;
    endtask

    // Drops valid and waits until every outstanding result has been seen.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_geoms.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic [dgc_pkg::KIND_W-1:0]  kind;
        logic [dgc_pkg::TOTAL_W-1:0] blocks;
        kind   = pick_kind();
        blocks = pick_capacity(kind);
        send_request(blocks, kind, calc_geometry(blocks, kind));
    endtask

    // Receiver: random stalls, plus a long hold-off when the stimulus asks for
    // one. The hold-off length is counted down here, not in the sender.
    always @(posedge clk)
    begin
        int hold_left;
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker and watchdog. Both sample the pre-edge values, so the
    // drivers' nonblocking updates at the same edge do not matter.
    always @(posedge clk)
    begin
        geom_t want;
        int    quiet;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_geoms.size() == 0)
                begin
                    $display("%0t: result with nothing pending: upd=%0d cyl=%0d heads=%0d spt=%0d",
                             $time, updated, cylinders, heads, sectors_per_track);
                    n_errors++;
                end
                else
                begin
                    want = pending_geoms.pop_front();
                    n_checked++;
                    if (updated !== want.upd)
                    begin
                        $display("%0t: updated mismatch, expected %0d, got %0d",
                                 $time, want.upd, updated);
                        n_errors++;
                    end
                    if (cylinders !== want.cyl)
                    begin
                        $display("%0t: cylinders mismatch, expected %0d, got %0d",
                                 $time, want.cyl, cylinders);
                        n_errors++;
                    end
                    if (heads !== want.hd)
                    begin
                        $display("%0t: heads mismatch, expected %0d, got %0d",
                                 $time, want.hd, heads);
                        n_errors++;
                    end
                    if (sectors_per_track !== want.spt)
                    begin
                        $display("%0t: sectors_per_track mismatch, expected %0d, got %0d",
                                 $time, want.spt, sectors_per_track);
                        n_errors++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet = quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, pending_geoms.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int         ph;
        int         k;
        probe_row_t r;

        // Directed table. Rows marked known carry a hand-derived geometry:
        // empty files, zero-size cards, exact synthesized fits including the
        // one above the cylinder limit and the one that wraps to zero, and the
        // all-ones capacity where nothing fits. Other rows use the predictor.
        add_probe(32'd0,          dgc_pkg::KIND_FILE,  1, 0, 0,    0,  0);
        add_probe(32'd0,          dgc_pkg::KIND_SYNTH, 1, 0, 0,    0,  0);
        add_probe(32'd0,          KIND_CARD,           1, 1, 0,    4,  63);
        add_probe(32'd0,          KIND_SPARE,          1, 1, 0,    4,  63);
        add_probe(32'd1,          dgc_pkg::KIND_FILE,  1, 1, 0,    4,  63);
        add_probe(32'd32,         dgc_pkg::KIND_SYNTH, 1, 1, 2,    1,  32);
        add_probe(32'd3200,       dgc_pkg::KIND_SYNTH, 1, 1, 101,  1,  32);
        add_probe(32'd35840000,   dgc_pkg::KIND_SYNTH, 1, 1, 4465, 16, 32);
        add_probe(32'd33553920,   dgc_pkg::KIND_SYNTH, 1, 1, 0,    16, 32);
        add_probe(32'hFFFFFFFF,   dgc_pkg::KIND_FILE,  1, 1, 4112, 17, 255);
        add_probe(32'hFFFFFFFF,   dgc_pkg::KIND_SYNTH, 1, 1, 4113, 17, 255);
        add_probe(32'hFFFFFFFF,   KIND_CARD,           1, 1, 4112, 17, 255);
        add_probe(32'd31,         dgc_pkg::KIND_SYNTH, 0, 0, 0, 0, 0);
        add_probe(32'd1048576,    dgc_pkg::KIND_FILE,  0, 0, 0, 0, 0);
        add_probe(32'd1048577,    dgc_pkg::KIND_FILE,  0, 0, 0, 0, 0);
        add_probe(32'd1048576,    dgc_pkg::KIND_SYNTH, 0, 0, 0, 0, 0);
        add_probe(32'd258048,     dgc_pkg::KIND_FILE,  0, 0, 0, 0, 0);
        add_probe(32'd4128516,    dgc_pkg::KIND_FILE,  0, 0, 0, 0, 0);
        add_probe(32'd267386800,  KIND_CARD,           0, 0, 0, 0, 0);
        add_probe(32'd267386880,  dgc_pkg::KIND_FILE,  0, 0, 0, 0, 0);
        add_probe(32'd267386880,  dgc_pkg::KIND_SYNTH, 0, 0, 0, 0, 0);
        add_probe(32'h80000000,   KIND_SPARE,          0, 0, 0, 0, 0);
        add_probe(32'hAAAAAAAA,   dgc_pkg::KIND_FILE,  0, 0, 0, 0, 0);
        add_probe(32'h55555555,   dgc_pkg::KIND_SYNTH, 0, 0, 0, 0, 0);

        // Reset is asserted from time zero and released once, at a clock edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[i])
        begin
            r = probe_rows[i];
            send_request(r.blocks, r.kind,
                         r.known ? r.want : calc_geometry(r.blocks, r.kind));
        end
        wait_all_results();

        // Random part in four idling phases: none, sender idle most cycles,
        // receiver stalling most cycles, and light idling on both sides.
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 59; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // Early in the first phase, hold the receiver off for a long
                // stretch while requests keep coming, so the output register
                // fills and the block backs up into its input.
                if (ph == 0 && k == 10)
                    hold_req = 1'b1;
                send_random();
                // Midway through each phase the sender stops until the block
                // has delivered everything it owes.
                if (k == PHASE_ITEMS / 2)
                    wait_all_results();
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_geoms.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_geoms.size());
            n_errors++;
        end

        $display("Sent %0d geometry requests (directed table plus random) over four idling phases,",
                 n_sent);
        $display("with a long output hold-off and drain pauses; %0d results compared.", n_checked);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== disk_geometry_from_capacity_unit.f =====
design/dgc_pkg.sv
design/dgc_div.sv
design/disk_geometry_from_capacity_unit.sv
bench/tb_top.sv
